/* hdl/tim_pkg.sv */
// Shared types and constants for the tour store with inversion mutation.
// No dependencies; every other file in hdl/ refers to this package.
package tim_pkg;

    localparam int VTX_W    = 9;
    localparam int IND_W    = 6;
    localparam int POS_W    = 6;
    localparam int RAND_W   = 16;
    localparam int LEN_O_W  = 7;
    localparam int FUNC_W   = 2;

    localparam int DEF_INDIVIDUALS = 64;
    localparam int DEF_NODES       = 64;

    localparam logic [FUNC_W-1:0] FUNC_WRITE  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_MUTATE = 2'd2;

    localparam logic [VTX_W-1:0]  END_MARK   = 9'h1FF;
    localparam int                SHORT_TOUR = 2;
    localparam logic [RAND_W-1:0] THR_RESET  = 16'd6554;

    typedef logic signed [VTX_W-1:0] t_vertex;

    // start pulse and dividend for the remainder unit
    typedef struct packed {
        logic              start;
        logic [RAND_W-1:0] dividend;
    } t_mod_req;

endpackage

/* hdl/tim_if.sv */
// Valid/ready channel interfaces for input operations and result beats.
// Depends on tim_pkg for field widths.
interface tim_in_if;
    logic                               valid;
    logic                               ready;
    logic [tim_pkg::FUNC_W-1:0]         func;
    logic [tim_pkg::IND_W-1:0]          individual;
    logic [tim_pkg::POS_W-1:0]          position;
    tim_pkg::t_vertex                   vertex_in;
    logic [tim_pkg::RAND_W-1:0]         rand_draw;
    logic [tim_pkg::RAND_W-1:0]         rand_start;
    logic [tim_pkg::RAND_W-1:0]         rand_goal;

    modport source (output valid, func, individual, position, vertex_in,
                    rand_draw, rand_start, rand_goal, input ready);
    modport sink   (input valid, func, individual, position, vertex_in,
                    rand_draw, rand_start, rand_goal, output ready);
endinterface

interface tim_out_if;
    logic                               valid;
    logic                               ready;
    tim_pkg::t_vertex                   vertex_out;
    logic                               mutated;
    logic [tim_pkg::LEN_O_W-1:0]        tour_length;
    logic [tim_pkg::POS_W-1:0]          seg_first;
    logic [tim_pkg::POS_W-1:0]          seg_last;

    modport source (output valid, vertex_out, mutated, tour_length, seg_first,
                    seg_last, input ready);
    modport sink   (input valid, vertex_out, mutated, tour_length, seg_first,
                    seg_last, output ready);
endinterface

/* hdl/tim_modu.sv */
// Iterative remainder unit: one dividend bit per cycle, restoring form.
// Depends on tim_pkg (RAND_W, t_mod_req).
module tim_modu #(
    parameter int NODES = tim_pkg::DEF_NODES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tim_pkg::t_mod_req             i_req,
    input  logic [$clog2(NODES+1)-1:0]    i_divisor,
    output logic                          o_done,
    output logic [$clog2(NODES+1)-1:0]    o_rem
);
    localparam int LW = $clog2(NODES + 1);
    localparam int CW = $clog2(tim_pkg::RAND_W);

    logic                        r_busy;
    logic                        r_done;
    logic [CW-1:0]               r_cnt;
    logic [tim_pkg::RAND_W-1:0]  r_dvd;
    logic [LW-1:0]               r_rem;
    logic [LW-1:0]               r_div;

    logic [LW:0] sh;
    logic [LW:0] dif;
    logic [LW-1:0] n_rem;

    always_comb begin
        sh  = {r_rem, r_dvd[tim_pkg::RAND_W-1]};
        dif = sh - {1'b0, r_div};
        if (sh >= {1'b0, r_div}) begin
            n_rem = dif[LW-1:0];
        end else begin
            n_rem = sh[LW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_dvd  <= i_req.dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_dvd <= r_dvd << 1;
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(tim_pkg::RAND_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_rem < r_div))
        else $error("remainder not below divisor");
    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |=> (r_busy && r_cnt == '0))
        else $error("start did not launch the unit");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(r_busy) && !r_busy))
        else $error("done without a finished run");

endmodule

/* hdl/tour_inversion_mutation_top.sv */
// Top level: tour store memory, operation sequencer and output register.
// Depends on tim_pkg, tim_if (tim_in_if, tim_out_if) and tim_modu.
//
//  channel   | dir | beat moves
//  ----------+-----+----------------------------------------------------------
//  i_item    | in  | func, individual, position, vertex_in, rand_draw/start/goal
//  o_res     | out | vertex_out, mutated, tour_length, seg_first, seg_last
//  i_cfg_*   | in  | mutation_threshold write (no read-back)
//
// A write is done in EXEC and a read captures its word in RDCAP. Mutate
// passing the draw scans L+1 entries (NODES with no end marker), one a
// cycle on read port A, then runs the two remainders, then per swapped
// pair reads both ends and writes each back on the one port.
// One item is in work at a time.
// Reset is synchronous and clears control only; the store has no reset.
// A result still waiting in the output register holds the next item in its
// last state, and input ready stays low until that beat is taken.
module tour_inversion_mutation_top #(
    parameter int INDIVIDUALS = tim_pkg::DEF_INDIVIDUALS,
    parameter int NODES       = tim_pkg::DEF_NODES
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [tim_pkg::RAND_W-1:0]  i_cfg_wdata,
    tim_in_if.sink                      i_item,
    tim_out_if.source                   o_res
);
    localparam int DEPTH = INDIVIDUALS * NODES;
    localparam int AW    = $clog2(DEPTH);
    localparam int LW    = $clog2(NODES + 1);
    localparam int PW    = $clog2(NODES);
    localparam int VW    = tim_pkg::VTX_W;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_EXEC    = 4'd1;
    localparam logic [3:0] S_RDCAP   = 4'd2;
    localparam logic [3:0] S_SCAN0   = 4'd3;
    localparam logic [3:0] S_SCAN    = 4'd4;
    localparam logic [3:0] S_MODA_GO = 4'd5;
    localparam logic [3:0] S_MODA_WT = 4'd6;
    localparam logic [3:0] S_MODB_GO = 4'd7;
    localparam logic [3:0] S_MODB_WT = 4'd8;
    localparam logic [3:0] S_ORDER   = 4'd9;
    localparam logic [3:0] S_SWRD    = 4'd10;
    localparam logic [3:0] S_SWWL    = 4'd11;
    localparam logic [3:0] S_SWWH    = 4'd12;
    localparam logic [3:0] S_DONE    = 4'd13;

    logic [3:0]                  r_state;
    logic [tim_pkg::RAND_W-1:0]  r_thr;

    // captured item
    logic [tim_pkg::FUNC_W-1:0]  r_func;
    logic [tim_pkg::IND_W-1:0]   r_ind;
    logic [tim_pkg::POS_W-1:0]   r_pos;
    logic [VW-1:0]               r_vin;
    logic [tim_pkg::RAND_W-1:0]  r_draw;
    logic [tim_pkg::RAND_W-1:0]  r_rs;
    logic [tim_pkg::RAND_W-1:0]  r_rg;
    logic [AW-1:0]               r_base;

    // work and result state
    logic [LW-1:0]               r_len;
    logic [PW-1:0]               r_a;
    logic [PW-1:0]               r_b;
    logic [PW-1:0]               r_lo;
    logic [PW-1:0]               r_hi;
    logic [PW-1:0]               r_first;
    logic [PW-1:0]               r_last;
    logic                        r_mut;
    logic [VW-1:0]               r_vout;
    logic [VW-1:0]               r_tmp;

    // output register
    logic                        r_ovalid;
    logic [VW-1:0]               r_o_vout;
    logic                        r_o_mut;
    logic [tim_pkg::LEN_O_W-1:0] r_o_len;
    logic [tim_pkg::POS_W-1:0]   r_o_first;
    logic [tim_pkg::POS_W-1:0]   r_o_last;

    // store
    logic [VW-1:0]               mem [DEPTH];
    logic [VW-1:0]               r_rd_a;
    logic [VW-1:0]               r_rd_b;
    logic [AW-1:0]               raddr_a;
    logic [AW-1:0]               raddr_b;
    logic [AW-1:0]               waddr;
    logic [VW-1:0]               wdata;
    logic                        we;

    tim_pkg::t_mod_req           mod_req;
    logic                        mod_done;
    logic [LW-1:0]               mod_rem;

    logic                        ind_ok;
    logic                        pos_ok;
    logic                        accept;
    logic                        out_free;
    logic [LW-1:0]               len_nx;
    logic [PW-1:0]               n_lo;
    logic [PW-1:0]               n_hi;

    assign ind_ok   = 32'(r_ind) < INDIVIDUALS;
    assign pos_ok   = 32'(r_pos) < NODES;
    assign accept   = i_item.valid && i_item.ready;
    assign out_free = !r_ovalid || o_res.ready;
    assign len_nx   = r_len + LW'(1);
    assign n_lo     = r_lo + PW'(1);
    assign n_hi     = r_hi - PW'(1);

    assign i_item.ready = (r_state == S_IDLE);

    // read and write addressing
    always_comb begin
        case (r_state)
            S_EXEC:  raddr_a = r_base + AW'(r_pos);
            S_SCAN:  raddr_a = r_base + AW'(len_nx);
            S_SWRD:  raddr_a = r_base + AW'(r_lo);
            default: raddr_a = r_base;
        endcase
        raddr_b = r_base + AW'(r_hi);

        we    = 1'b0;
        waddr = r_base + AW'(r_pos);
        wdata = r_vin;
        case (r_state)
            S_EXEC: begin
                we = (r_func == tim_pkg::FUNC_WRITE) && ind_ok && pos_ok;
            end
            S_SWWL: begin
                we    = 1'b1;
                waddr = r_base + AW'(r_lo);
                wdata = r_rd_b;
            end
            S_SWWH: begin
                we    = 1'b1;
                waddr = r_base + AW'(r_hi);
                wdata = r_tmp;
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rd_a <= mem[raddr_a];
        r_rd_b <= mem[raddr_b];
    end

    assign mod_req.start    = (r_state == S_MODA_GO) || (r_state == S_MODB_GO);
    assign mod_req.dividend = (r_state == S_MODA_GO) ? r_rs : r_rg;

    tim_modu #(
        .NODES (NODES)
    ) u_modu (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (mod_req),
        .i_divisor (r_len),
        .o_done    (mod_done),
        .o_rem     (mod_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_thr    <= tim_pkg::THR_RESET;
            r_ovalid <= 1'b0;
            r_mut    <= 1'b0;
            r_len    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
            if (r_state == S_DONE && out_free) begin
                r_ovalid <= 1'b1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_func  <= i_item.func;
                        r_ind   <= i_item.individual;
                        r_pos   <= i_item.position;
                        r_vin   <= i_item.vertex_in;
                        r_draw  <= i_item.rand_draw;
                        r_rs    <= i_item.rand_start;
                        r_rg    <= i_item.rand_goal;
                        r_base  <= AW'(i_item.individual) * AW'(NODES);
                        r_len   <= '0;
                        r_first <= '0;
                        r_last  <= '0;
                        r_mut   <= 1'b0;
                        r_vout  <= '0;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    case (r_func)
                        tim_pkg::FUNC_READ: begin
                            r_state <= (ind_ok && pos_ok) ? S_RDCAP : S_DONE;
                        end
                        tim_pkg::FUNC_MUTATE: begin
                            if (ind_ok && r_ind != '0 && r_draw <= r_thr) begin
                                r_state <= S_SCAN0;
                            end else begin
                                r_state <= S_DONE;
                            end
                        end
                        default: begin
                            r_state <= S_DONE;
                        end
                    endcase
                end
                S_RDCAP: begin
                    r_vout  <= r_rd_a;
                    r_state <= S_DONE;
                end
                S_SCAN0: begin
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    // r_rd_a holds entry r_len; next entry is already requested
                    if (r_rd_a == tim_pkg::END_MARK) begin
                        r_state <= (r_len > LW'(tim_pkg::SHORT_TOUR)) ? S_MODA_GO
                                                                      : S_DONE;
                    end else if (r_len == LW'(NODES - 1)) begin
                        r_len   <= len_nx;
                        r_state <= (len_nx > LW'(tim_pkg::SHORT_TOUR)) ? S_MODA_GO
                                                                       : S_DONE;
                    end else begin
                        r_len <= len_nx;
                    end
                end
                S_MODA_GO: begin
                    r_state <= S_MODA_WT;
                end
                S_MODA_WT: begin
                    if (mod_done) begin
                        r_a     <= PW'(mod_rem);
                        r_state <= S_MODB_GO;
                    end
                end
                S_MODB_GO: begin
                    r_state <= S_MODB_WT;
                end
                S_MODB_WT: begin
                    if (mod_done) begin
                        r_b     <= PW'(mod_rem);
                        r_state <= S_ORDER;
                    end
                end
                S_ORDER: begin
                    r_mut <= 1'b1;
                    if (r_b < r_a) begin
                        r_lo    <= r_b;
                        r_hi    <= r_a;
                        r_first <= r_b;
                        r_last  <= r_a;
                    end else begin
                        r_lo    <= r_a;
                        r_hi    <= r_b;
                        r_first <= r_a;
                        r_last  <= r_b;
                    end
                    r_state <= (r_a != r_b) ? S_SWRD : S_DONE;
                end
                S_SWRD: begin
                    r_state <= S_SWWL;
                end
                S_SWWL: begin
                    r_tmp   <= r_rd_a;
                    r_state <= S_SWWH;
                end
                S_SWWH: begin
                    r_lo    <= n_lo;
                    r_hi    <= n_hi;
                    r_state <= (n_lo < n_hi) ? S_SWRD : S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_o_vout  <= r_vout;
                        r_o_mut   <= r_mut;
                        r_o_len   <= tim_pkg::LEN_O_W'(r_len);
                        r_o_first <= tim_pkg::POS_W'(r_first);
                        r_o_last  <= tim_pkg::POS_W'(r_last);
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_res.valid       = r_ovalid;
    assign o_res.vertex_out  = r_o_vout;
    assign o_res.mutated     = r_o_mut;
    assign o_res.tour_length = r_o_len;
    assign o_res.seg_first   = r_o_first;
    assign o_res.seg_last    = r_o_last;

    a_we_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |-> ((r_state == S_EXEC && r_func == tim_pkg::FUNC_WRITE)
                || r_state == S_SWWL || r_state == S_SWWH))
        else $error("store written outside a write or swap");
    a_swap_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWRD) |-> (r_lo < r_hi))
        else $error("swap pointers crossed");
    a_mut_long_tour: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_mut) |-> (r_len > LW'(tim_pkg::SHORT_TOUR)))
        else $error("mutation flagged on a short tour");
    a_mod_only_long: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mod_req.start |-> (r_len > LW'(tim_pkg::SHORT_TOUR)))
        else $error("remainder started with a short length");

endmodule
